[rtl/ole_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg: shared types and codes of the ordered list engine
// operation, status and cell command codes, plus the stream field widths
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int VAL_W       = 32;
	localparam int POS_W       = 6;
	localparam int OP_W        = 3;
	localparam int STAT_W      = 3;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 56;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_SEARCH    = 3'd2,
		OP_DELETE    = 3'd3,
		OP_DUMP_FWD  = 3'd4,
		OP_DUMP_REV  = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_BAD_POS   = 3'd4
	} status_t;

	// the command that every cell of the chain carries out
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_ROT_LEFT,
		CELL_ROT_RIGHT,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_PULL
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [VAL_W-1:0]  value;
	} cell_cmd_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_WALK
	} fsm_t;

endpackage

[rtl/ole_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_cell: one slot of the list chain
// holds one entry and takes its value from a neighbor or the command
// ----------------------------------------------------------------------------
module ole_cell (
	input  logic                       clk,
	input  ole_pkg::cell_cmd_t         cmd,
	input  logic                       mark,
	input  logic [ole_pkg::VAL_W-1:0]  left_val,
	input  logic [ole_pkg::VAL_W-1:0]  right_val,
	output logic [ole_pkg::VAL_W-1:0]  val
);
	import ole_pkg::*;

	logic [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_ROT_LEFT:   val_q <= right_val;
			CELL_ROT_RIGHT:  val_q <= left_val;
			CELL_PUSH_FRONT: val_q <= mark ? cmd.value : left_val;
			CELL_PUSH_BACK: begin
				if (mark)
					val_q <= cmd.value;
			end
			CELL_PULL: begin
				if (mark)
					val_q <= right_val;
			end
			default: ;
		endcase
	end

	assign val = val_q;

endmodule

[rtl/ole_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ctrl: sequencer of the ordered list engine
// decodes transactions, steps the cell chain and drives the result register
// ----------------------------------------------------------------------------
module ole_ctrl #(
	parameter  int DEPTH = 32,
	localparam int CW    = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ole_pkg::OP_W-1:0]    operation,
	input  logic [ole_pkg::VAL_W-1:0]   value,
	input  logic [ole_pkg::POS_W-1:0]   position,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ole_pkg::STAT_W-1:0]  status,
	output logic [ole_pkg::VAL_W-1:0]   entry_value,
	output logic [ole_pkg::POS_W-1:0]   front_position,
	output logic [ole_pkg::POS_W-1:0]   rear_position,
	output logic [ole_pkg::POS_W-1:0]   item_count,
	output logic                        last,
	input  logic [ole_pkg::VAL_W-1:0]   head_val,
	output ole_pkg::cell_cmd_t          cmd,
	output logic [DEPTH-1:0]            mark,
	output logic                        busy,
	output logic [CW-1:0]               fill_count
);
	import ole_pkg::*;

	localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;

	fsm_t              state_q, state_d;
	op_t               op_q;
	logic [VAL_W-1:0]  val_q;
	logic [POS_W-1:0]  pos_q;
	logic [CW-1:0]     k_q, k_d;
	logic [CW-1:0]     count_q, count_d;
	logic              found_q, found_d;
	logic [CW-1:0]     fp_q, fp_d;
	logic [CW-1:0]     lidx_q, lidx_d;
	logic [VAL_W-1:0]  gone_q, gone_d;
	logic              accept;

	// result register
	logic              ovalid_q;
	status_t           ostat_q;
	logic [VAL_W-1:0]  oval_q;
	logic [POS_W-1:0]  ofp_q, orp_q, ocnt_q;
	logic              olast_q;

	logic              emit;
	status_t           e_stat;
	logic [VAL_W-1:0]  e_val;
	logic [CW-1:0]     e_fp, e_rp;
	logic              e_last;

	logic              adv;
	logic              at_end;
	logic [MW-1:0]     k_w, cnt_w, pos_w, pin_w;
	logic [DEPTH-1:0]  back_mark, pull_mark;

	assign adv    = !ovalid_q || out_ready;
	assign at_end = (k_q == CW'(DEPTH));
	assign k_w    = MW'(k_q);
	assign cnt_w  = MW'(count_q);
	assign pos_w  = MW'(pos_q);
	assign pin_w  = MW'(position);

	for (genvar g = 0; g < DEPTH; g++) begin : g_mark
		assign back_mark[g] = (count_q == CW'(g));
		assign pull_mark[g] = (MW'(g + 1) >= pos_w);
	end

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		count_d   = count_q;
		found_d   = found_q;
		fp_d      = fp_q;
		lidx_d    = lidx_q;
		gone_d    = gone_q;
		cmd.op    = CELL_HOLD;
		cmd.value = value;
		mark      = '0;
		in_ready  = 1'b0;
		accept    = 1'b0;
		emit      = 1'b0;
		e_stat    = STAT_OK;
		e_val     = '0;
		e_fp      = '0;
		e_rp      = '0;
		e_last    = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				in_ready = adv;
				accept   = in_valid && adv;
				if (accept) begin
					k_d     = '0;
					found_d = 1'b0;
					fp_d    = '0;
					lidx_d  = '0;
					case (op_t'(operation))
						OP_INS_FRONT, OP_INS_BACK: begin
							emit  = 1'b1;
							e_val = value;
							if (count_q == CW'(DEPTH)) begin
								e_stat = STAT_FULL;
							end else begin
								if (op_t'(operation) == OP_INS_FRONT) begin
									cmd.op = CELL_PUSH_FRONT;
									mark   = DEPTH'(1);
								end else begin
									cmd.op = CELL_PUSH_BACK;
									mark   = back_mark;
								end
								count_d = count_q + 1'b1;
							end
						end
						OP_SEARCH: begin
							if (count_q == '0) begin
								emit   = 1'b1;
								e_stat = STAT_EMPTY;
								e_val  = value;
							end else begin
								state_d = FSM_WALK;
							end
						end
						OP_DELETE: begin
							if (count_q == '0) begin
								emit   = 1'b1;
								e_stat = STAT_EMPTY;
							end else if (position == '0 || pin_w > cnt_w) begin
								emit   = 1'b1;
								e_stat = STAT_BAD_POS;
							end else begin
								state_d = FSM_WALK;
							end
						end
						OP_DUMP_FWD, OP_DUMP_REV: begin
							if (count_q == '0) begin
								emit   = 1'b1;
								e_stat = STAT_EMPTY;
							end else begin
								state_d = FSM_WALK;
							end
						end
						default: ;
					endcase
				end
			end
			FSM_WALK: begin
				if (adv) begin
					if (!at_end) begin
						cmd.op = (op_q == OP_DUMP_REV) ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
						k_d    = k_q + 1'b1;
					end
					case (op_q)
						OP_SEARCH: begin
							if (at_end) begin
								emit    = 1'b1;
								e_val   = val_q;
								state_d = FSM_IDLE;
								if (found_q) begin
									e_fp = fp_q;
									e_rp = count_q - lidx_q;
								end else begin
									e_stat = STAT_NOT_FOUND;
								end
							end else if (k_w < cnt_w && head_val == val_q) begin
								if (!found_q)
									fp_d = k_q + 1'b1;
								found_d = 1'b1;
								lidx_d  = k_q;
							end
						end
						OP_DELETE: begin
							if (at_end) begin
								cmd.op  = CELL_PULL;
								mark    = pull_mark;
								count_d = count_q - 1'b1;
								emit    = 1'b1;
								e_val   = gone_q;
								state_d = FSM_IDLE;
							end else if (k_w + 1'b1 == pos_w) begin
								gone_d = head_val;
							end
						end
						OP_DUMP_FWD: begin
							if (k_w < cnt_w) begin
								emit   = 1'b1;
								e_val  = head_val;
								e_last = (k_w + 1'b1 == cnt_w);
							end
							if (at_end)
								state_d = FSM_IDLE;
						end
						OP_DUMP_REV: begin
							// head holds entry DEPTH-k once k rotations are done
							if (k_w + cnt_w > MW'(DEPTH)) begin
								emit   = 1'b1;
								e_val  = head_val;
								e_last = at_end;
							end
							if (at_end)
								state_d = FSM_IDLE;
						end
						default: state_d = FSM_IDLE;
					endcase
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			if (emit)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		k_q     <= k_d;
		found_q <= found_d;
		fp_q    <= fp_d;
		lidx_q  <= lidx_d;
		gone_q  <= gone_d;
		if (accept) begin
			op_q  <= op_t'(operation);
			val_q <= value;
			pos_q <= position;
		end
		if (emit) begin
			ostat_q <= e_stat;
			oval_q  <= e_val;
			ofp_q   <= POS_W'(e_fp);
			orp_q   <= POS_W'(e_rp);
			ocnt_q  <= POS_W'(count_d);
			olast_q <= e_last;
		end
	end

	assign out_valid      = ovalid_q;
	assign status         = ostat_q;
	assign entry_value    = oval_q;
	assign front_position = ofp_q;
	assign rear_position  = orp_q;
	assign item_count     = ocnt_q;
	assign last           = olast_q;
	assign busy           = (state_q == FSM_WALK);
	assign fill_count     = count_q;

endmodule

[rtl/ordered_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded ordered list of signed 32-bit values
// a ring of cells holds the list front to rear; a sequencer rotates the ring
// to search, delete and dump; insert front shifts the ring, insert back
// writes only the cell just past the rear
//
// channel   direction  tdata (lsb first)                         tuser       tlast
// s_axis    in         value[31:0], position[37:32], pad          operation   -
// m_axis    out        entry_value[31:0], front_position[37:32],  status      last
//                      rear_position[43:38], item_count[49:44], pad
//
// insert front / insert back and every fault result are answered without a ring walk
// search, delete and dump walk the ring once, one rotation step of the cell
//   chain per cycle while the result register is empty or being drained;
//   the chain length sets the number of steps
// a walk step waits while the result register is full and not taken
// reset clears the entry count and the result valid; cell contents stay
//   undefined until written and are never read beyond the count
// a new transaction is taken only between operations, and only when the
//   result register is empty or being drained in the same cycle
//
module ordered_list_engine #(
	parameter int DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ole_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // value, position
	input  logic [ole_pkg::OP_W-1:0]        s_axis_tuser,   // operation
	// master side
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [ole_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // entry_value, front_position,
	                                                        // rear_position, item_count
	output logic [ole_pkg::STAT_W-1:0]      m_axis_tuser,   // status
	output logic                            m_axis_tlast    // last
);
	import ole_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	// ring of cells, index 0 is the front of the list
	logic [VAL_W-1:0]  cell_val [DEPTH];
	cell_cmd_t         cmd;
	logic [DEPTH-1:0]  mark;

	// result fields before packing
	logic [VAL_W-1:0]  entry_value;
	logic [POS_W-1:0]  front_position, rear_position, item_count;

	// status toward the checks below
	logic              busy;
	logic [CW-1:0]     fill_count;

	ole_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.operation      (s_axis_tuser),
		.value          (s_axis_tdata[VAL_W-1:0]),
		.position       (s_axis_tdata[VAL_W+POS_W-1:VAL_W]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.status         (m_axis_tuser),
		.entry_value    (entry_value),
		.front_position (front_position),
		.rear_position  (rear_position),
		.item_count     (item_count),
		.last           (m_axis_tlast),
		.head_val       (cell_val[0]),
		.cmd            (cmd),
		.mark           (mark),
		.busy           (busy),
		.fill_count     (fill_count)
	);

	// each cell sees its two ring neighbors; the ends wrap around
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		ole_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.mark      (mark[g]),
			.left_val  (cell_val[(g + DEPTH - 1) % DEPTH]),
			.right_val (cell_val[(g + 1) % DEPTH]),
			.val       (cell_val[g])
		);
	end

	// pack result transaction, pad bits are zero
	assign m_axis_tdata = {
		(M_TDATA_W - VAL_W - 3 * POS_W)'(0),
		item_count,
		rear_position,
		front_position,
		entry_value
	};

	// no new transaction while the ring is being walked
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready)
		else $error("input taken during a ring walk");

	// the count never passes the ring length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= CW'(DEPTH))
		else $error("entry count beyond depth");

	// one operation changes the count by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count == $past(fill_count) ||
		fill_count == $past(fill_count) + 1'b1 ||
		fill_count == $past(fill_count) - 1'b1)
		else $error("entry count jumped");

	// a pending full result means the list is still full
	a_full_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STAT_FULL) |-> fill_count == CW'(DEPTH))
		else $error("full status with room left");

endmodule

[test/ole_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_checker: reply checker for the ordered list engine
// keeps its own copy of the list, works out the replies owed for each
// accepted command and compares every reply transaction field by field
// ----------------------------------------------------------------------------
module ole_checker #(
	parameter int DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [ole_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [ole_pkg::OP_W-1:0]        s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [ole_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic [ole_pkg::STAT_W-1:0]      m_tuser,
	input  logic                            m_tlast,
	output int                              mismatches,
	output int                              replies_due,
	output int                              replies_seen,
	output int                              list_len
);
	import ole_pkg::*;

	typedef struct {
		status_t           status;
		logic [VAL_W-1:0]  entry_value;
		logic [POS_W-1:0]  front_position;
		logic [POS_W-1:0]  rear_position;
		logic [POS_W-1:0]  item_count;
		logic              last;
	} list_reply_t;

	logic [VAL_W-1:0] list_entries[$];
	list_reply_t      owed_replies[$];

	initial begin
		mismatches   = 0;
		replies_due  = 0;
		replies_seen = 0;
		list_len     = 0;
	end

	function automatic void owe_reply(status_t st, logic [VAL_W-1:0] v, int fp, int rp,
			logic fin);
		list_reply_t r;
		r.status         = st;
		r.entry_value    = v;
		r.front_position = POS_W'(fp);
		r.rear_position  = POS_W'(rp);
		r.item_count     = POS_W'(list_entries.size());
		r.last           = fin;
		owed_replies.push_back(r);
	endfunction

	task automatic apply_list_op(input logic [OP_W-1:0] code, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		int n;
		int fp;
		int rp;
		int i;
		logic [VAL_W-1:0] gone;
		n  = list_entries.size();
		fp = 0;
		rp = 0;
		case (code)
			OP_INS_FRONT, OP_INS_BACK: begin
				if (n >= DEPTH) begin
					owe_reply(STAT_FULL, val, 0, 0, 1'b1);
				end else begin
					if (code == OP_INS_FRONT) begin
						list_entries.push_front(val);
					end else begin
						list_entries.push_back(val);
					end
					owe_reply(STAT_OK, val, 0, 0, 1'b1);
				end
			end
			OP_SEARCH: begin
				if (n == 0) begin
					owe_reply(STAT_EMPTY, val, 0, 0, 1'b1);
				end else begin
					for (i = 0; i < n; i++) begin
						if (fp == 0 && list_entries[i] == val) fp = i + 1;
						if (rp == 0 && list_entries[n-1-i] == val) rp = i + 1;
					end
					if (fp == 0) begin
						owe_reply(STAT_NOT_FOUND, val, 0, 0, 1'b1);
					end else begin
						owe_reply(STAT_OK, val, fp, rp, 1'b1);
					end
				end
			end
			OP_DELETE: begin
				if (n == 0) begin
					owe_reply(STAT_EMPTY, '0, 0, 0, 1'b1);
				end else if (pos == 0 || pos > n) begin
					owe_reply(STAT_BAD_POS, '0, 0, 0, 1'b1);
				end else begin
					gone = list_entries[pos-1];
					list_entries.delete(pos - 1);
					owe_reply(STAT_OK, gone, 0, 0, 1'b1);
				end
			end
			OP_DUMP_FWD, OP_DUMP_REV: begin
				if (n == 0) begin
					owe_reply(STAT_EMPTY, '0, 0, 0, 1'b1);
				end else begin
					for (i = 0; i < n; i++) begin
						owe_reply(STAT_OK, list_entries[(code == OP_DUMP_FWD) ? i : n - 1 - i],
							0, 0, i == n - 1);
					end
				end
			end
			default: begin
				// spare codes are dropped by the block
			end
		endcase
	endtask

	function automatic void check_field(string field, logic [VAL_W-1:0] want,
			logic [VAL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	task automatic compare_reply();
		list_reply_t want;
		if (owed_replies.size() == 0) begin
			$error("reply with nothing owed: status %0d value %0h", m_tuser, m_tdata[31:0]);
			mismatches++;
		end else begin
			want = owed_replies.pop_front();
			replies_seen++;
			check_field("status", want.status, m_tuser);
			check_field("entry_value", want.entry_value, m_tdata[31:0]);
			check_field("front_position", want.front_position, m_tdata[37:32]);
			check_field("rear_position", want.rear_position, m_tdata[43:38]);
			check_field("item_count", want.item_count, m_tdata[49:44]);
			check_field("last", want.last, m_tlast);
		end
	endtask

	// reply side first: a reply never belongs to a command taken on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) compare_reply();
			if (s_tvalid && s_tready) apply_list_op(s_tuser, s_tdata[31:0], s_tdata[37:32]);
			replies_due <= owed_replies.size();
			list_len    <= list_entries.size();
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the ordered list engine
// drives list commands with random gaps on both streams, a directed opening
// and random phases that fill, drain and mix the list; the checker beside
// the block tracks the list and checks every reply
// ----------------------------------------------------------------------------
module tb_top;
	import ole_pkg::*;

	localparam int LIST_DEPTH   = 32;
	localparam int RX_LONG_HOLD = 300;
	localparam int RANDOM_OPS   = 250;
	// generous ceiling: every command a full dump with worst-case stalls, taken 3x over
	localparam longint TIMEOUT_NS = 25_000_000;

	// codes the block does not know and must drop
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;    // value[31:0], position[37:32], pad
	logic [OP_W-1:0]       s_axis_tuser;    // operation
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;    // entry_value, front_position,
	                                        // rear_position, item_count, pad
	logic [STAT_W-1:0]     m_axis_tuser;    // status
	logic                  m_axis_tlast;    // last

	int mismatches;
	int replies_due;
	int replies_seen;
	int list_len;

	// stimulus bookkeeping
	int ops_sent   = 0;
	int spare_sent = 0;
	int peak_len   = 0;
	bit steady        = 1'b0;   // no idling on either side while set
	bit long_hold_req = 1'b0;   // asks the reply sink for one long stall

	always #5 clk = ~clk;

	ordered_list_engine #(
		.DEPTH(LIST_DEPTH)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	ole_checker #(
		.DEPTH(LIST_DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_axis_tvalid),
		.s_tready     (s_axis_tready),
		.s_tdata      (s_axis_tdata),
		.s_tuser      (s_axis_tuser),
		.m_tvalid     (m_axis_tvalid),
		.m_tready     (m_axis_tready),
		.m_tdata      (m_axis_tdata),
		.m_tuser      (m_axis_tuser),
		.m_tlast      (m_axis_tlast),
		.mismatches   (mismatches),
		.replies_due  (replies_due),
		.replies_seen (replies_seen),
		.list_len     (list_len)
	);

	// idle stretch length: mostly short, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// a small pool of values recurs so searches hit and duplicates pile up
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			4: return VAL_W'($urandom_range(1, 4));
			default: return $urandom();
		endcase
	endfunction

	// one command transaction; valid stays up across back-to-back commands
	task automatic offer(input logic [OP_W-1:0] code, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tdata  <= {2'b00, pos, val};
		s_axis_tuser  <= code;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (code == OP_SPARE_A || code == OP_SPARE_B) begin
			spare_sent++;
		end else begin
			ops_sent++;
		end
		// list_len lags the command just taken by one, which is fine for steering
		if (list_len > peak_len) peak_len = list_len;
	endtask

	// random command with the given insert and delete weights in percent
	task automatic random_op(input int ins_pct, input int del_pct);
		int r;
		logic [OP_W-1:0] code;
		logic [POS_W-1:0] pos;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			code = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
		end else if (r < 3 + ins_pct) begin
			code = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
		end else if (r < 3 + ins_pct + del_pct) begin
			code = OP_DELETE;
		end else if ($urandom_range(0, 99) < 60) begin
			code = OP_SEARCH;
		end else begin
			code = $urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_REV;
		end
		// mostly a position inside the list, sometimes anything the field holds
		if (list_len == 0 || $urandom_range(0, 9) == 0) begin
			pos = POS_W'($urandom_range(0, 63));
		end else begin
			pos = POS_W'($urandom_range(1, list_len));
		end
		offer(code, pick_value(), pos);
	endtask

	// reply sink: random ready with idle stretches, plus one long stall on request
	initial begin : reply_sink
		int idle_left;
		idle_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_left > 0) begin
				m_axis_tready <= 1'b0;
				idle_left--;
			end else if (long_hold_req) begin
				// block fills up and must push back on the command side
				long_hold_req = 1'b0;
				idle_left     = RX_LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 30) begin
				idle_left     = idle_len() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : run_limit
		#(TIMEOUT_NS);
		$display("timeout with %0d replies still owed", replies_due);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int epoch;
		int kind;
		int len;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		arst_n        = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ---- directed opening ----
		// every reading command on an empty list
		offer(OP_SEARCH, 32'h0000_0005, 6'd1);
		offer(OP_DELETE, 32'h0, 6'd1);
		offer(OP_DUMP_FWD, 32'h0, 6'd0);
		offer(OP_DUMP_REV, 32'h0, 6'd0);
		// spare codes produce nothing
		offer(OP_SPARE_A, 32'hffff_ffff, 6'd63);
		offer(OP_SPARE_B, 32'h0, 6'd0);
		// value extremes at both ends, one duplicate
		offer(OP_INS_FRONT, 32'h7fff_ffff, 6'd0);
		offer(OP_INS_BACK, 32'h8000_0000, 6'd0);
		offer(OP_INS_FRONT, 32'h0000_0000, 6'd0);
		offer(OP_INS_BACK, 32'hffff_ffff, 6'd0);
		offer(OP_INS_BACK, 32'h7fff_ffff, 6'd0);
		// duplicate gives different front and rear positions, then a miss
		offer(OP_SEARCH, 32'h7fff_ffff, 6'd0);
		offer(OP_SEARCH, 32'h0001_2345, 6'd0);
		offer(OP_DUMP_FWD, 32'h0, 6'd0);
		offer(OP_DUMP_REV, 32'h0, 6'd0);
		// bad positions: zero, one past the count, field maximum
		offer(OP_DELETE, 32'h0, 6'd0);
		offer(OP_DELETE, 32'h0, 6'd6);
		offer(OP_DELETE, 32'h0, 6'd63);
		// front, rear, middle, then down to a single entry and empty
		offer(OP_DELETE, 32'h0, 6'd1);
		offer(OP_DELETE, 32'h0, 6'd4);
		offer(OP_DELETE, 32'h0, 6'd2);
		offer(OP_DELETE, 32'h0, 6'd2);
		offer(OP_DUMP_FWD, 32'h0, 6'd0);
		offer(OP_DELETE, 32'h0, 6'd1);

		// ---- fill to full while the reply side stalls for a long time ----
		long_hold_req = 1'b1;
		while (list_len < LIST_DEPTH)
			offer($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK, pick_value(), 6'd0);
		repeat (3) offer(OP_INS_BACK, pick_value(), 6'd0);
		// full-length dumps are the longest reply bursts
		offer(OP_DUMP_FWD, 32'h0, 6'd0);
		offer(OP_DUMP_REV, 32'h0, 6'd0);
		offer(OP_SEARCH, pick_value(), 6'd0);

		// ---- random phases: fill, drain or mixed ----
		epoch = 0;
		while (ops_sent < RANDOM_OPS) begin
			kind   = $urandom_range(0, 2);
			len    = $urandom_range(15, 35);
			steady = (epoch == 2);
			if (epoch == 4) long_hold_req = 1'b1;
			repeat (len) begin
				case (kind)
					0: random_op(70, 10);
					1: random_op(10, 60);
					default: random_op(35, 25);
				endcase
			end
			if (epoch == 3) begin
				// command side goes quiet until every reply is in
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				while (replies_due != 0) @(negedge clk);
			end
			epoch++;
		end
		steady = 1'b0;

		// ---- drain to empty and dump the empty list ----
		while (list_len > 0)
			offer(OP_DELETE, pick_value(), POS_W'($urandom_range(1, list_len)));
		offer(OP_DUMP_REV, pick_value(), 6'd0);

		// ---- wind down ----
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (replies_due != 0) @(negedge clk);
		repeat (2 * LIST_DEPTH + 8) @(negedge clk);

		$display("run covered %0d list commands and %0d spare codes, %0d replies checked",
			ops_sent, spare_sent, replies_seen);
		$display("list went from empty to %0d of %0d entries and back to empty",
			peak_len, LIST_DEPTH);
		if (mismatches == 0 && replies_due == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ole_ctrl.sv
rtl/ordered_list_engine.sv
test/ole_checker.sv
test/tb_top.sv
